// ===== rtl/bri2d_pkg.sv =====
// Shared types and constants for the 2D ray/box intersection unit.
package bri2d_pkg;

  typedef enum logic [2:0] {
    REG_CORNER_A_X  = 3'd0,
    REG_CORNER_A_Y  = 3'd1,
    REG_CORNER_B_X  = 3'd2,
    REG_CORNER_B_Y  = 3'd3,
    REG_INSET_MARGIN = 3'd4
  } cfg_reg_t;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W = 32;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] distance_t;
    logic               origin_inside;
    logic               zero_direction;
  } out_t;

  // one slab quotient in flight
  typedef struct packed {
    logic        neg;
    logic        sat;
    logic [31:0] md;
    logic [31:0] rem;
    logic [31:0] num;
    logic [31:0] q;
  } lane_t;

  // per-ray flags carried beside the quotients
  typedef struct packed {
    logic in_box;
    logic zero;
    logic horiz;
    logic vert;
    logic on_slab;
  } side_t;

endpackage

// ===== rtl/box_ray_intersect_2d_unit.sv =====
// Top level: pipelined slab-method ray versus axis-aligned box test.
//
//  channel | ports                          | payload
//  in      | in_valid, in_ready, in_data    | ray origin and direction
//  out     | out_valid, out_ready, out_data | hit, t, inside, zero flags
//  cfg     | cfg_we, cfg_index, cfg_wdata   | box corners and inset margin
//
// One ray per cycle unless the output stalls; stages: prep, 32 divider
// bit stages, slab merge, output register. The four slab quotients run
// through a restoring divider that retires one quotient bit per stage.
// rst_n is synchronous; it clears valid bits and loads register resets.
// The whole pipeline holds while the output register is full and not taken.
module box_ray_intersect_2d_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bri2d_pkg::in_t                in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bri2d_pkg::out_t               out_data,
  input  logic                          cfg_we,
  input  logic [bri2d_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bri2d_pkg::CFG_W-1:0]   cfg_wdata
);
  import bri2d_pkg::*;

  localparam int STEPS = 32;
  localparam int NW = 33 + FRAC_BITS;
  localparam int HW = NW - 32;
  localparam int NL = 4;

  logic signed [31:0] ax_r, ay_r, bx_r, by_r, m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r <= '0;
      ay_r <= '0;
      bx_r <= '0;
      by_r <= '0;
      m_r  <= '1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CORNER_A_X:   ax_r <= cfg_wdata;
        REG_CORNER_A_Y:   ay_r <= cfg_wdata;
        REG_CORNER_B_X:   bx_r <= cfg_wdata;
        REG_CORNER_B_Y:   by_r <= cfg_wdata;
        REG_INSET_MARGIN: m_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic signed [31:0] lox, hix, loy, hiy;
  assign lox = (ax_r < bx_r) ? ax_r : bx_r;
  assign hix = (ax_r < bx_r) ? bx_r : ax_r;
  assign loy = (ay_r < by_r) ? ay_r : by_r;
  assign hiy = (ay_r < by_r) ? by_r : ay_r;

  logic adv;
  logic out_valid_r;
  out_t out_r;
  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------- prep stage ----------------
  lane_t lane_a [NL];
  side_t side_a;

  always_comb begin
    logic signed [32:0] diff [NL];
    logic signed [31:0] den  [NL];
    logic [32:0]        mn;
    logic [31:0]        md;
    logic [NW-1:0]      n;
    logic [HW-1:0]      nh;
    logic signed [33:0] sx_lo, sx_hi, sy_lo, sy_hi;
    diff[0] = 33'(lox) - 33'(in_data.origin_x);
    diff[1] = 33'(hix) - 33'(in_data.origin_x);
    diff[2] = 33'(loy) - 33'(in_data.origin_y);
    diff[3] = 33'(hiy) - 33'(in_data.origin_y);
    den[0]  = in_data.dir_x;
    den[1]  = in_data.dir_x;
    den[2]  = in_data.dir_y;
    den[3]  = in_data.dir_y;
    for (int l = 0; l < NL; l++) begin
      mn = diff[l][32] ? 33'(-diff[l]) : 33'(diff[l]);
      md = den[l][31] ? 32'(-den[l]) : 32'(den[l]);
      n  = NW'(mn) << FRAC_BITS;
      nh = n[NW-1:32];
      lane_a[l].neg = diff[l][32] ^ den[l][31];
      lane_a[l].sat = 32'(nh) >= md;
      lane_a[l].md  = md;
      lane_a[l].rem = 32'(nh);
      lane_a[l].num = n[31:0];
      lane_a[l].q   = '0;
    end
    sx_lo = 34'(lox) + 34'(m_r);
    sx_hi = 34'(hix) - 34'(m_r);
    sy_lo = 34'(loy) + 34'(m_r);
    sy_hi = 34'(hiy) - 34'(m_r);
    side_a.in_box = (34'(in_data.origin_x) >= sx_lo) && (34'(in_data.origin_x) <= sx_hi) &&
                    (34'(in_data.origin_y) >= sy_lo) && (34'(in_data.origin_y) <= sy_hi);
    side_a.zero  = (in_data.dir_x == '0) && (in_data.dir_y == '0);
    side_a.horiz = (in_data.dir_y == '0);
    side_a.vert  = (in_data.dir_x == '0);
    side_a.on_slab = (in_data.dir_y == '0) ?
                       (in_data.origin_y >= loy && in_data.origin_y <= hiy) :
                       (in_data.origin_x >= lox && in_data.origin_x <= hix);
  end

  // ---------------- divider stages ----------------
  function automatic lane_t div_step(lane_t x);
    lane_t       y;
    logic [32:0] r2;
    logic        qb;
    y  = x;
    r2 = {x.rem, x.num[31]};
    qb = r2 >= {1'b0, x.md};
    if (qb) r2 = r2 - {1'b0, x.md};
    y.rem = r2[31:0];
    y.num = {x.num[30:0], 1'b0};
    y.q   = {x.q[30:0], qb};
    return y;
  endfunction

  lane_t div_r  [STEPS+1][NL];
  side_t side_r [STEPS+1];
  logic  vld_r  [STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= STEPS; s++) vld_r[s] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int s = 0; s < STEPS; s++) vld_r[s+1] <= vld_r[s];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side_a;
      for (int l = 0; l < NL; l++) div_r[0][l] <= lane_a[l];
      for (int s = 0; s < STEPS; s++) begin
        side_r[s+1] <= side_r[s];
        for (int l = 0; l < NL; l++) div_r[s+1][l] <= div_step(div_r[s][l]);
      end
    end
  end

  // ---------------- slab merge ----------------
  function automatic logic signed [31:0] sat_t(lane_t x);
    logic signed [31:0] r;
    if (x.neg) begin
      if (x.sat || (x.q[31] && (x.q[30:0] != '0))) r = 32'sh8000_0000;
      else r = 32'(-x.q);
    end else begin
      if (x.sat || x.q[31]) r = 32'sh7FFF_FFFF;
      else r = 32'(x.q);
    end
    return r;
  endfunction

  logic signed [31:0] lo_nxt, hi_nxt, lo_r, hi_r;
  logic ok_nxt, ok_r, mvld_r;
  side_t mside_r;

  always_comb begin
    logic signed [31:0] u0, u1, t0, t1, ua, ub, ta, tb;
    u0 = sat_t(div_r[STEPS][0]);
    u1 = sat_t(div_r[STEPS][1]);
    t0 = sat_t(div_r[STEPS][2]);
    t1 = sat_t(div_r[STEPS][3]);
    ua = (u0 > u1) ? u1 : u0;
    ub = (u0 > u1) ? u0 : u1;
    ta = (t0 > t1) ? t1 : t0;
    tb = (t0 > t1) ? t0 : t1;
    if (side_r[STEPS].horiz) begin
      lo_nxt = ua;
      hi_nxt = ub;
      ok_nxt = side_r[STEPS].on_slab;
    end else if (side_r[STEPS].vert) begin
      lo_nxt = ta;
      hi_nxt = tb;
      ok_nxt = side_r[STEPS].on_slab;
    end else begin
      lo_nxt = (ta > ua) ? ta : ua;
      hi_nxt = (tb < ub) ? tb : ub;
      ok_nxt = !(((ta > ua) ? ta : ua) > ((tb < ub) ? tb : ub));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      mvld_r      <= vld_r[STEPS];
      out_valid_r <= mvld_r;
    end
  end

  out_t out_nxt;
  always_comb begin
    out_nxt.origin_inside  = mside_r.in_box;
    out_nxt.zero_direction = mside_r.zero;
    out_nxt.hit            = !mside_r.zero && ok_r && (hi_r > 0);
    out_nxt.distance_t     = out_nxt.hit ? ((lo_r <= 0) ? hi_r : lo_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
      ok_r    <= ok_nxt;
      mside_r <= side_r[STEPS];
      out_r   <= out_nxt;
    end
  end

endmodule

// ===== tb/box_ray_intersect_2d_unit_chk.sv =====
// Checker for the ray/box unit: mirrors config, predicts each result and compares.
module box_ray_intersect_2d_unit_chk (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  bri2d_pkg::in_t                  in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  bri2d_pkg::out_t                 out_data,
  input  logic                            cfg_we,
  input  logic [bri2d_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bri2d_pkg::CFG_W-1:0]     cfg_wdata,
  output int                              fail_count,
  output int                              pending
);
  import bri2d_pkg::*;

  localparam int FRAC = 16;

  logic signed [31:0] box_ax, box_ay, box_bx, box_by, margin;
  out_t hit_queue[$];

  assign pending = hit_queue.size();

  // (num << FRAC) / den, truncated toward zero, clamped to 32-bit signed
  function automatic logic signed [63:0] slab_t(logic signed [63:0] num,
                                                logic signed [63:0] den);
    logic neg;
    logic [63:0] mn, md, q;
    neg = (num < 0) != (den < 0);
    mn = (num < 0) ? -num : num;
    md = (den < 0) ? -den : den;
    q = (mn << FRAC) / md;
    if (neg) begin
      if (q > 64'd2147483648) return -64'sd2147483648;
      return -$signed(q);
    end
    if (q > 64'd2147483647) return 64'sd2147483647;
    return $signed(q);
  endfunction

  function automatic out_t trace_ray(in_t r);
    logic signed [63:0] lox, hix, loy, hiy, ox, oy, dx, dy, m;
    logic signed [63:0] lo, hi, t0, t1, u0, u1, tmp;
    logic ok;
    out_t res;
    lox = (box_ax < box_bx) ? box_ax : box_bx;
    hix = (box_ax < box_bx) ? box_bx : box_ax;
    loy = (box_ay < box_by) ? box_ay : box_by;
    hiy = (box_ay < box_by) ? box_by : box_ay;
    ox = r.origin_x; oy = r.origin_y; dx = r.dir_x; dy = r.dir_y; m = margin;
    res = '0;
    res.origin_inside = ox >= lox + m && ox <= hix - m && oy >= loy + m && oy <= hiy - m;
    if (dx == 0 && dy == 0) begin
      res.zero_direction = 1'b1;
      return res;
    end
    ok = 1'b1;
    lo = 0; hi = 0;
    if (dy == 0) begin
      if (oy < loy || oy > hiy) ok = 1'b0;
      else begin
        lo = slab_t(lox - ox, dx);
        hi = slab_t(hix - ox, dx);
      end
    end else if (dx == 0) begin
      if (ox < lox || ox > hix) ok = 1'b0;
      else begin
        lo = slab_t(loy - oy, dy);
        hi = slab_t(hiy - oy, dy);
      end
    end else begin
      t0 = slab_t(loy - oy, dy);
      t1 = slab_t(hiy - oy, dy);
      u0 = slab_t(lox - ox, dx);
      u1 = slab_t(hix - ox, dx);
      if (t0 > t1) begin tmp = t0; t0 = t1; t1 = tmp; end
      if (u0 > u1) begin tmp = u0; u0 = u1; u1 = tmp; end
      lo = (t0 > u0) ? t0 : u0;
      hi = (t1 < u1) ? t1 : u1;
      if (lo > hi) ok = 1'b0;
    end
    if (lo > hi) begin tmp = lo; lo = hi; hi = tmp; end
    if (ok && hi > 0) begin
      res.hit = 1'b1;
      res.distance_t = (lo <= 0) ? hi[31:0] : lo[31:0];
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      box_ax <= '0; box_ay <= '0; box_bx <= '0; box_by <= '0;
      margin <= -32'sd1;
      fail_count <= 0;
      hit_queue.delete();
    end else begin
      if (in_valid && in_ready) hit_queue.push_back(trace_ray(in_data));
      if (out_valid && out_ready) begin
        if (hit_queue.size() == 0) begin
          $error("unexpected transaction: %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = hit_queue.pop_front();
          if (out_data !== want) begin
            fail_count <= fail_count + 1;
            if (out_data.hit !== want.hit)
              $error("hit: expected %0d, got %0d", want.hit, out_data.hit);
            if (out_data.distance_t !== want.distance_t)
              $error("distance_t: expected %0d, got %0d", want.distance_t,
                     out_data.distance_t);
            if (out_data.origin_inside !== want.origin_inside)
              $error("origin_inside: expected %0d, got %0d", want.origin_inside,
                     out_data.origin_inside);
            if (out_data.zero_direction !== want.zero_direction)
              $error("zero_direction: expected %0d, got %0d", want.zero_direction,
                     out_data.zero_direction);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_CORNER_A_X:   box_ax <= cfg_wdata;
          REG_CORNER_A_Y:   box_ay <= cfg_wdata;
          REG_CORNER_B_X:   box_bx <= cfg_wdata;
          REG_CORNER_B_Y:   box_by <= cfg_wdata;
          REG_INSET_MARGIN: margin <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== tb/box_ray_intersect_2d_unit_tb.sv =====
// Testbench top: clock, reset, config phases, ray stimulus and verdict.
module box_ray_intersect_2d_unit_tb;
  import bri2d_pkg::*;

  localparam int LATENCY = 35;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_AT = 900;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_t in_data;
  out_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  int fail_count, pending;
  int cycles;

  box_ray_intersect_2d_unit dut (.*);

  box_ray_intersect_2d_unit_chk chk (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off to back up the pipe
  initial begin
    int gap;
    int taken;
    out_ready = 1'b0;
    taken = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (taken == HOLD_AT) begin
        out_ready <= 1'b0;
        repeat (200) @(posedge clk);
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk iff out_valid);
      taken++;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_box(logic [31:0] ax, logic [31:0] ay, logic [31:0] bx,
                         logic [31:0] by, logic [31:0] m);
    write_reg(REG_CORNER_A_X, ax);
    write_reg(REG_CORNER_A_Y, ay);
    write_reg(REG_CORNER_B_X, bx);
    write_reg(REG_CORNER_B_Y, by);
    write_reg(REG_INSET_MARGIN, m);
    cfg_we <= 1'b0;
  endtask

  task automatic send_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] dx,
                          logic [31:0] dy, bit pace);
    int gap;
    gap = (pace && $urandom_range(0, 2) != 0) ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{ox, oy, dx, dy};
    @(posedge clk iff in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk iff pending == 0);
    repeat (4) @(posedge clk);
  endtask

  // random 32-bit value, often small or at an extreme
  function automatic logic [31:0] pick();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2: return 32'($signed($urandom_range(0, 8)) - 4) <<< 16;
      3: return 32'(int'($urandom_range(0, 40)) - 20);
      default: return 32'(int'($urandom_range(0, 2000000)) - 1000000) <<< 4;
    endcase
  endfunction

  // a ray from around the box, random direction, some axis-aligned, zero or extreme
  task automatic random_ray(int lo, int hi);
    logic [31:0] ox, oy, dx, dy;
    ox = (lo - 200000) + int'($urandom_range(0, (hi - lo) + 400000));
    oy = (lo - 200000) + int'($urandom_range(0, (hi - lo) + 400000));
    dx = int'($urandom_range(0, 400000)) - 200000;
    dy = int'($urandom_range(0, 400000)) - 200000;
    case ($urandom_range(0, 9))
      0: dx = '0;
      1: dy = '0;
      2: begin dx = '0; dy = '0; end
      3: begin ox = pick(); dx = pick(); end
      4: begin oy = pick(); dy = pick(); dx = $urandom; end
      5: begin ox = lo; oy = hi; end
      default: ;
    endcase
    send_ray(ox, oy, dx, dy, 1'b1);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset box: a point at the origin with a one-LSB grow
    send_ray(32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    send_ray(-32'sh10000, 32'h0, 32'h10000, 32'h0, 1'b0);
    drain();

    // corners given reversed; directed extremes and special cases
    set_box(32'h00050000, 32'h00040000, -32'sh00020000, -32'sh00010000, 32'h00008000);
    send_ray(-32'sh000a0000, 32'h0, 32'h00010000, 32'h0, 1'b0);   // horizontal hit
    send_ray(-32'sh000a0000, 32'h00090000, 32'h00010000, 32'h0, 1'b0); // off slab
    send_ray(32'h0, -32'sh000a0000, 32'h0, 32'h00020000, 1'b0);   // vertical hit
    send_ray(32'h00090000, 32'h0, 32'h0, 32'h00010000, 1'b0);     // vertical miss
    send_ray(32'h0, 32'h0, 32'h00010000, 32'h00010000, 1'b0);     // inside: exit
    send_ray(32'h000a0000, 32'h0, 32'h00010000, 32'h0, 1'b0);     // box behind
    send_ray(-32'sh000a0000, -32'sh000a0000, 32'h00010000, 32'h00030000, 1'b0); // empty
    send_ray(32'h0, 32'h0, 32'h0, 32'h0, 1'b0);                   // zero direction
    send_ray(32'h80000000, 32'h0, 32'h00000001, 32'h0, 1'b0);     // saturates
    send_ray(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 1'b0);
    send_ray(-32'sh00020000, 32'h0, 32'h7fffffff, 32'h0, 1'b0);   // tiny t truncates
    send_ray(32'h0, 32'h0, 32'hffffffff, 32'h00000001, 1'b0);
    send_ray(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 1'b0);
    drain();

    // full-range box, negative margin extreme
    set_box(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    send_ray(32'h0, 32'h0, 32'h00000001, 32'h0, 1'b0);
    send_ray(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h00000001, 1'b0);
    drain();

    // random phases: box, margin, then rays; the receiver hold-off lands mid-run
    for (int ph = 0; ph < 10; ph++) begin
      int a, b;
      a = int'($urandom_range(0, 600000)) - 300000;
      b = int'($urandom_range(0, 600000)) - 300000;
      if (ph == 9) set_box(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                           32'h7fffffff);
      else if (ph % 3 == 2) set_box(a, a, a, b, $urandom);
      else set_box(a, b, b, a, int'($urandom_range(0, 40000)) - 20000);
      for (int k = 0; k < 200; k++) begin
        if (a < b) random_ray(a, b);
        else random_ray(b, a);
      end
      drain();
    end

    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
